/* rtl/core/aitp_pkg.sv */
// Shared constants, widths and helper functions for the Aitoff projection pipeline.
`default_nettype none

package aitp_pkg;

	// Angle format and field widths
	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int LON_W = 22;
	localparam int LAT_W = 20;
	localparam int X_W   = 21;
	localparam int Y_W   = 20;

	// Datapath widths
	localparam int ANG_W = 22;  // unsigned angle into a sine/cosine unit
	localparam int SC_W  = 32;  // Q30 sine/cosine result
	localparam int CW    = 34;  // rotator datapath

	// Step counts
	localparam int ITERS    = 30;  // rotator iterations
	localparam int SQ_STEPS = 31;  // square root result bits
	localparam int QBITS    = 34;  // quotient bits before clamping

	// Register levels of each section and of the whole block
	localparam int SC_LAT  = ITERS + 6;
	localparam int DIV_LAT = QBITS + 2;
	localparam int LATENCY = SC_LAT + 4 + SQ_STEPS + 1 + ITERS + 1 + DIV_LAT + 2;

	// Fixed-point constants
	localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sd1686629713;
	localparam logic [34:0]          RAD_Q40      = 35'd19190098069;
	localparam logic [29:0]          DEG_Q24      = 30'd961263669;
	localparam logic [14:0]          RECIP_45     = 15'd23302;
	localparam int                   RECIP_SH     = 20;

	// atan(2^-i) in Q30
	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic signed [CW-1:0] v;
		case (i)
			0: v = 34'sd843314857;
			1: v = 34'sd497837829;
			2: v = 34'sd263043837;
			3: v = 34'sd133525159;
			4: v = 34'sd67021687;
			5: v = 34'sd33543516;
			6: v = 34'sd16775851;
			7: v = 34'sd8388437;
			8: v = 34'sd4194283;
			9: v = 34'sd2097149;
			default: v = CW'(longint'(1) << (30 - i));
		endcase
		return v;
	endfunction

	// Saturation bound: deg degrees in the angle format, limited to the field width
	function automatic longint sat_lim(input int frac, input int deg, input int w);
		longint lim;
		longint wl;
		lim = longint'(deg) << frac;
		wl  = (longint'(1) << (w - 1)) - 1;
		return (lim > wl) ? wl : lim;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/aitp_sincos.sv */
// Pipelined sine/cosine unit: quadrant reduction and a 30-step rotation CORDIC in Q30.
`default_nettype none

module aitp_sincos #(
	parameter int ANGLE_FRAC_BITS = aitp_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_v,
	input  logic [aitp_pkg::ANG_W-1:0]         angle,
	output logic                               out_v,
	output logic signed [aitp_pkg::SC_W-1:0]   sin_val,
	output logic signed [aitp_pkg::SC_W-1:0]   cos_val
);
	import aitp_pkg::*;

	typedef enum logic [1:0] {
		QUAD_FIRST,
		QUAD_SECOND,
		QUAD_THIRD,
		QUAD_FOURTH
	} quad_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		quad_t                quad;
	} rot_t;

	localparam longint     Q90  = longint'(90) << (ANGLE_FRAC_BITS + 1);
	localparam int         TSH  = ANGLE_FRAC_BITS + 2;
	localparam int         ZSH  = ANGLE_FRAC_BITS + 11;
	localparam logic [63:0] ZRND = 64'd1 << (ANGLE_FRAC_BITS + 10);
	localparam logic [17:0] RAD_LO = RAD_Q40[17:0];
	localparam logic [16:0] RAD_HI = RAD_Q40[34:18];

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [ANG_W-1:0] a_s1, a_s2;
	logic [6:0]       q_s2;
	logic [ANG_W-1:0] r_s3;
	quad_t            quad_s3, quad_s4;
	logic [39:0]      plo_s4;
	logic [38:0]      phi_s4;

	rot_t             rot_s [0:ITERS];
	logic [ITERS:0]   rv_s;

	logic [ANG_W-1:0]    t_c;
	logic [ANG_W+14:0]   tq_c;
	logic [63:0]         rq_c;
	logic [63:0]         zsum_c;

	// Quadrant count by reciprocal of 45 on the angle over 2^(F+2)
	assign t_c  = a_s1 >> TSH;
	assign tq_c = t_c * RECIP_45;
	assign rq_c = 64'(a_s2) - 64'(q_s2) * 64'(Q90);

	// Residual to Q30 radians, rounded
	assign zsum_c = ((64'(phi_s4) << 18) + 64'(plo_s4) + ZRND) >> ZSH;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			rv_s  <= '0;
			out_v <= 1'b0;
		end else begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			rv_s  <= {rv_s[ITERS-1:0], v_s4};
			out_v <= rv_s[ITERS];
		end
	end

	// Reduction stages
	always_ff @(posedge clk) begin
		a_s1    <= angle;
		a_s2    <= a_s1;
		q_s2    <= tq_c[RECIP_SH+6:RECIP_SH];
		r_s3    <= rq_c[ANG_W-1:0];
		quad_s3 <= quad_t'(q_s2[1:0]);
		plo_s4  <= r_s3 * RAD_LO;
		phi_s4  <= r_s3 * RAD_HI;
		quad_s4 <= quad_s3;
		rot_s[0] <= '{x: INV_GAIN_Q30, y: '0, z: CW'(zsum_c), quad: quad_s4};
	end

	// One rotation per stage
	for (genvar i = 0; i < ITERS; i++) begin : g_rot
		rot_t nxt;
		always_comb begin
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			dx  = rot_s[i].y >>> i;
			dy  = rot_s[i].x >>> i;
			nxt = rot_s[i];
			if (rot_s[i].z >= 0) begin
				nxt.x = rot_s[i].x - dx;
				nxt.y = rot_s[i].y + dy;
				nxt.z = rot_s[i].z - atan_q30(i);
			end else begin
				nxt.x = rot_s[i].x + dx;
				nxt.y = rot_s[i].y - dy;
				nxt.z = rot_s[i].z + atan_q30(i);
			end
		end
		always_ff @(posedge clk) begin
			rot_s[i+1] <= nxt;
		end
	end

	// Quadrant fold-back
	always_ff @(posedge clk) begin
		unique case (rot_s[ITERS].quad)
			QUAD_FIRST: begin
				sin_val <= SC_W'(rot_s[ITERS].y);
				cos_val <= SC_W'(rot_s[ITERS].x);
			end
			QUAD_SECOND: begin
				sin_val <= SC_W'(rot_s[ITERS].x);
				cos_val <= SC_W'(-rot_s[ITERS].y);
			end
			QUAD_THIRD: begin
				sin_val <= SC_W'(-rot_s[ITERS].y);
				cos_val <= SC_W'(-rot_s[ITERS].x);
			end
			default: begin
				sin_val <= SC_W'(-rot_s[ITERS].x);
				cos_val <= SC_W'(rot_s[ITERS].y);
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/aitp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, quotient clamped to 2^32.
`default_nettype none

module aitp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	input  logic [63:0] num,
	input  logic [30:0] den,
	output logic        out_v,
	output logic [32:0] quo
);
	import aitp_pkg::*;

	typedef struct packed {
		logic [63:0]      rem;
		logic [30:0]      den;
		logic [QBITS-1:0] q;
		logic             sat;
	} dv_t;

	localparam logic [QBITS-1:0] QMAX = QBITS'(64'd1 << 32);

	dv_t            dv_s [0:QBITS];
	logic [QBITS:0] dv_v;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v  <= '0;
			out_v <= 1'b0;
		end else begin
			dv_v  <= {dv_v[QBITS-1:0], in_v};
			out_v <= dv_v[QBITS];
		end
	end

	// Entry: flag quotients that cannot fit the quotient bits
	always_ff @(posedge clk) begin
		dv_s[0] <= '{rem: num, den: den, q: '0,
			sat: (66'(num) >= (66'(den) << QBITS))};
	end

	// One trial subtraction per stage, most significant bit first
	for (genvar j = 0; j < QBITS; j++) begin : g_div
		localparam int K = QBITS - 1 - j;
		dv_t nxt;
		always_comb begin
			nxt = dv_s[j];
			if (66'(dv_s[j].rem) >= (66'(dv_s[j].den) << K)) begin
				nxt.rem  = dv_s[j].rem - 64'(66'(dv_s[j].den) << K);
				nxt.q[K] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			dv_s[j+1] <= nxt;
		end
	end

	// Clamp
	always_ff @(posedge clk) begin
		if (dv_s[QBITS].sat || (dv_s[QBITS].q > QMAX)) begin
			quo <= QMAX[32:0];
		end else begin
			quo <= dv_s[QBITS].q[32:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/aitoff_projection.sv */
// Top level of the Aitoff map projection pipeline.
//
// Usage:
//   Input channel: longitude and latitude in degrees with ANGLE_FRAC_BITS
//   fraction bits; a transfer happens at each rising edge with start high
//   and busy low. busy stays low, so a new position may enter every cycle.
//   Output channel: done is high for one cycle with map_x and map_y; the
//   result is taken at the edge that ends that cycle.
//   Throughput: one position per cycle. The pipeline depth is set by
//   the two 30-step rotators, the 31-step square root and the 34-step
//   divider, each one stage per step. The receiver cannot stall; every
//   result appears exactly once, in order. Reset clears the valid bits
//   only: anything in flight is dropped and done stays low until new
//   positions arrive.
`default_nettype none

module aitoff_projection #(
	parameter int ANGLE_FRAC_BITS = aitp_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [aitp_pkg::LON_W-1:0] longitude,
	input  logic signed [aitp_pkg::LAT_W-1:0] latitude,
	output logic                              done,
	output logic signed [aitp_pkg::X_W-1:0]   map_x,
	output logic signed [aitp_pkg::Y_W-1:0]   map_y
);
	import aitp_pkg::*;

	typedef struct packed {
		logic lon_nonneg;
		logic lat_neg;
	} tag_t;

	typedef struct packed {
		logic        xneg;
		logic        yneg;
		logic [31:0] mx;
		logic [31:0] my;
	} side_t;

	typedef struct packed {
		logic [60:0]          n;
		logic [61:0]          res;
		logic signed [CW-1:0] c;
		side_t                side;
	} sq_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] ang;
		logic [30:0]          s;
		side_t                side;
	} vec_t;

	localparam longint      XLIM = sat_lim(ANGLE_FRAC_BITS, 180, X_W);
	localparam longint      YLIM = sat_lim(ANGLE_FRAC_BITS, 90, Y_W);
	localparam int          DSH  = 54 - ANGLE_FRAC_BITS;
	localparam logic [63:0] DRND = 64'd1 << (DSH - 1);
	localparam logic [63:0] ONE60 = 64'd1 << 60;

	// Input conditioning
	longint           lon_l;
	longint           lon_red;
	longint           lat_l;
	logic [ANG_W-1:0] a_lon;
	logic [ANG_W-1:0] a_lat;
	logic             in_v;

	assign busy  = 1'b0;
	assign in_v  = start && !busy;
	assign lon_l = longint'(longitude);
	assign lat_l = longint'(latitude);
	assign lon_red = (lon_l > (longint'(180) << ANGLE_FRAC_BITS)) ?
		lon_l - (longint'(360) << ANGLE_FRAC_BITS) : lon_l;
	assign a_lon = ANG_W'((lon_red < 0) ? -lon_red : lon_red);
	assign a_lat = ANG_W'(2 * ((lat_l < 0) ? -lat_l : lat_l));

	// Sine and cosine of half the longitude and of the latitude
	logic                   scl_v, scb_v;
	logic signed [SC_W-1:0] sh_c, ch_c, sl_c, cl_c;

	aitp_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lon (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (in_v),
		.angle   (a_lon),
		.out_v   (scl_v),
		.sin_val (sh_c),
		.cos_val (ch_c)
	);

	aitp_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lat (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (in_v),
		.angle   (a_lat),
		.out_v   (scb_v),
		.sin_val (sl_c),
		.cos_val (cl_c)
	);

	// Sign tags ride alongside the sine/cosine units
	tag_t tag_s [1:SC_LAT];

	always_ff @(posedge clk) begin
		tag_s[1] <= '{lon_nonneg: (lon_red >= 0), lat_neg: (lat_l < 0)};
		for (int k = 2; k <= SC_LAT; k++) begin
			tag_s[k] <= tag_s[k-1];
		end
	end

	// Pipeline registers
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [63:0]     pc_s1, px_s1;
	logic signed [SC_W-1:0] sl_s1;
	tag_t                   tag_s1;
	logic signed [CW-1:0]   c_s2, c_s3;
	logic [31:0]            cabs_s2;
	side_t                  side_s2, side_s3;
	logic [63:0]            c2_s3;
	logic [SQ_STEPS:0]      sqv_s;
	sq_t                    sq_s [0:SQ_STEPS];
	logic [ITERS:0]         atv_s;
	vec_t                   at_s [0:ITERS];
	logic [63:0]            numx_s4, numy_s4;
	logic [30:0]            den_s4;
	side_t                  side_s4;
	logic [62:0]            prodx_s5, prody_s5;
	logic                   xneg_s5, yneg_s5;

	// Valid chain
	logic divx_v, divy_v;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sqv_s <= '0;
			atv_s <= '0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s1  <= scl_v && scb_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			sqv_s <= {sqv_s[SQ_STEPS-1:0], v_s3};
			atv_s <= {atv_s[ITERS-1:0], sqv_s[SQ_STEPS]};
			v_s4  <= atv_s[ITERS];
			v_s5  <= divx_v && divy_v;
			done  <= v_s5;
		end
	end

	// Products of the trigonometric terms
	always_ff @(posedge clk) begin
		pc_s1  <= cl_c * ch_c;
		px_s1  <= cl_c * sh_c;
		sl_s1  <= sl_c;
		tag_s1 <= tag_s[SC_LAT];
	end

	// Rescale: c in Q30, x numerator in Q30 with the factor two
	logic signed [63:0] c_l, nx_l;
	assign c_l  = pc_s1 >>> 30;
	assign nx_l = px_s1 >>> 29;

	always_ff @(posedge clk) begin
		c_s2         <= CW'(c_l);
		cabs_s2      <= 32'((c_l < 0) ? -c_l : c_l);
		side_s2.xneg <= (nx_l < 0) ^ tag_s1.lon_nonneg;
		side_s2.mx   <= 32'((nx_l < 0) ? -nx_l : nx_l);
		side_s2.yneg <= (sl_s1 < 0) ^ tag_s1.lat_neg;
		side_s2.my   <= 32'((sl_s1 < 0) ? -sl_s1 : sl_s1);
	end

	// c squared, then radicand 1 - c^2 floored at zero
	always_ff @(posedge clk) begin
		c2_s3   <= cabs_s2 * cabs_s2;
		c_s3    <= c_s2;
		side_s3 <= side_s2;
		sq_s[0] <= '{n: (c2_s3 >= ONE60) ? '0 : 61'(ONE60 - c2_s3), res: '0,
			c: c_s3, side: side_s3};
	end

	// Square root, one result bit per stage
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		localparam logic [61:0] BIT = 62'd1 << (2 * (SQ_STEPS - 1 - j));
		sq_t nxt;
		always_comb begin
			logic [62:0] trial;
			trial = 63'(sq_s[j].res) + 63'(BIT);
			nxt   = sq_s[j];
			if (63'(sq_s[j].n) >= trial) begin
				nxt.n   = 61'(63'(sq_s[j].n) - trial);
				nxt.res = (sq_s[j].res >> 1) + BIT;
			end else begin
				nxt.res = sq_s[j].res >> 1;
			end
		end
		always_ff @(posedge clk) begin
			sq_s[j+1] <= nxt;
		end
	end

	// Vectoring entry: fold the left half plane onto the right
	always_ff @(posedge clk) begin
		at_s[0].s    <= sq_s[SQ_STEPS].res[30:0];
		at_s[0].side <= sq_s[SQ_STEPS].side;
		if (sq_s[SQ_STEPS].c < 0) begin
			at_s[0].x   <= CW'(sq_s[SQ_STEPS].res[30:0]);
			at_s[0].y   <= -sq_s[SQ_STEPS].c;
			at_s[0].ang <= HALF_PI_Q30;
		end else begin
			at_s[0].x   <= sq_s[SQ_STEPS].c;
			at_s[0].y   <= CW'(sq_s[SQ_STEPS].res[30:0]);
			at_s[0].ang <= '0;
		end
	end

	// Vectoring CORDIC for alpha
	for (genvar i = 0; i < ITERS; i++) begin : g_vec
		vec_t nxt;
		always_comb begin
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			dx  = at_s[i].y >>> i;
			dy  = at_s[i].x >>> i;
			nxt = at_s[i];
			if (at_s[i].y > 0) begin
				nxt.x   = at_s[i].x + dx;
				nxt.y   = at_s[i].y - dy;
				nxt.ang = at_s[i].ang + atan_q30(i);
			end else begin
				nxt.x   = at_s[i].x - dx;
				nxt.y   = at_s[i].y + dy;
				nxt.ang = at_s[i].ang - atan_q30(i);
			end
		end
		always_ff @(posedge clk) begin
			at_s[i+1] <= nxt;
		end
	end

	// Numerators times alpha; zero sin(alpha) passes the numerator through
	logic [31:0] alpha_c;
	logic        s_zero;
	logic [63:0] nax_c, nay_c;
	assign alpha_c = (at_s[ITERS].ang < 0) ? '0 : 32'(at_s[ITERS].ang);
	assign s_zero  = (at_s[ITERS].s == '0);
	assign nax_c   = at_s[ITERS].side.mx * alpha_c;
	assign nay_c   = at_s[ITERS].side.my * alpha_c;

	always_ff @(posedge clk) begin
		numx_s4 <= s_zero ? 64'(at_s[ITERS].side.mx) : nax_c;
		numy_s4 <= s_zero ? 64'(at_s[ITERS].side.my) : nay_c;
		den_s4  <= s_zero ? 31'd1 : at_s[ITERS].s;
		side_s4 <= at_s[ITERS].side;
	end

	// Division by sin(alpha)
	logic [32:0] quox_c, quoy_c;

	aitp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (v_s4),
		.num    (numx_s4),
		.den    (den_s4),
		.out_v  (divx_v),
		.quo    (quox_c)
	);

	aitp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (v_s4),
		.num    (numy_s4),
		.den    (den_s4),
		.out_v  (divy_v),
		.quo    (quoy_c)
	);

	// Signs ride alongside the dividers
	logic [1:0] sg_s [1:DIV_LAT];
	always_ff @(posedge clk) begin
		sg_s[1] <= {side_s4.xneg, side_s4.yneg};
		for (int k = 2; k <= DIV_LAT; k++) begin
			sg_s[k] <= sg_s[k-1];
		end
	end

	// Radians to degrees
	always_ff @(posedge clk) begin
		prodx_s5 <= quox_c * DEG_Q24;
		prody_s5 <= quoy_c * DEG_Q24;
		xneg_s5  <= sg_s[DIV_LAT][1];
		yneg_s5  <= sg_s[DIV_LAT][0];
	end

	// Round, saturate, apply sign
	logic [63:0] mx_c, my_c, mxs_c, mys_c;
	assign mx_c  = (64'(prodx_s5) + DRND) >> DSH;
	assign my_c  = (64'(prody_s5) + DRND) >> DSH;
	assign mxs_c = (mx_c > 64'(XLIM)) ? 64'(XLIM) : mx_c;
	assign mys_c = (my_c > 64'(YLIM)) ? 64'(YLIM) : my_c;

	always_ff @(posedge clk) begin
		map_x <= xneg_s5 ? -X_W'(mxs_c) : X_W'(mxs_c);
		map_y <= yneg_s5 ? -Y_W'(mys_c) : Y_W'(mys_c);
	end

endmodule

`default_nettype wire

/* rtl/core/aitp_chk.sv */
// Port-level checker for the Aitoff projection block, bound to the top level.
`default_nettype none

module aitp_chk #(
	parameter int ANGLE_FRAC_BITS = aitp_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic signed [aitp_pkg::LON_W-1:0] longitude,
	input logic signed [aitp_pkg::LAT_W-1:0] latitude,
	input logic                              done,
	input logic signed [aitp_pkg::X_W-1:0]   map_x,
	input logic signed [aitp_pkg::Y_W-1:0]   map_y
);
	import aitp_pkg::*;

	localparam longint XLIM = sat_lim(ANGLE_FRAC_BITS, 180, X_W);
	localparam longint YLIM = sat_lim(ANGLE_FRAC_BITS, 90, Y_W);

	// Every input transfer yields a result after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after input transfer");

	// No result without a matching input transfer
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without input transfer");

	// Results stay within the saturation bounds
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((longint'(map_x) <= XLIM) && (longint'(map_x) >= -XLIM) &&
			(longint'(map_y) <= YLIM) && (longint'(map_y) >= -YLIM)))
		else $error("result outside saturation bounds");

	// The origin projects to the origin
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (longitude == '0) && (latitude == '0)) |->
			##LATENCY ((map_x == '0) && (map_y == '0)))
		else $error("origin not mapped to origin");

endmodule

bind aitoff_projection aitp_chk #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_aitp_chk (.*);

`default_nettype wire

/* test/tb_aitoff_projection.sv */
// Self-checking testbench for the Aitoff projection pipeline.

module tb_aitoff_projection;
	timeunit 1ns;
	timeprecision 1ps;
	import aitp_pkg::*;

	localparam int F = ANGLE_FRAC_BITS_DEF;

	typedef struct {
		logic signed [X_W-1:0] x;
		logic signed [Y_W-1:0] y;
	} map_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [LON_W-1:0] longitude = '0;
	logic signed [LAT_W-1:0] latitude = '0;
	logic done;
	logic signed [X_W-1:0] map_x;
	logic signed [Y_W-1:0] map_y;

	map_pos_t pending_pos[$];
	int errors = 0;
	bit gaps_on = 1'b1;

	aitoff_projection u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.longitude(longitude), .latitude(latitude),
		.done(done), .map_x(map_x), .map_y(map_y)
	);

	always #5 clk = ~clk;

	// arctangent of 2^-i in Q30
	function automatic longint atan_step(input int i);
		longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10)
			return head[i];
		return longint'(1) << (30 - i);
	endfunction

	// Rotation CORDIC on a nonnegative angle in units of 2^-(F+1) degree
	function automatic void sin_cos(input longint unsigned a, output longint sn,
			output longint cs);
		longint unsigned q90, q, r;
		longint x, y, z, dx, dy;
		q90 = longint'(90) << (F + 1);
		a = a % (4 * q90);
		q = a / q90;
		r = a - q * q90;
		z = longint'((r * 64'd19190098069 + (64'd1 << (F + 10))) >> (F + 11));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		case (q)
			0: begin sn = y;  cs = x;  end
			1: begin sn = x;  cs = -y; end
			2: begin sn = -y; cs = -x; end
			default: begin sn = -x; cs = y; end
		endcase
	endfunction

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC angle of (xv, yv)
	function automatic longint vec_angle(input longint yv, input longint xv);
		longint ang, t, dx, dy;
		ang = 0;
		if (xv < 0) begin
			t = xv; xv = yv; yv = -t; ang = 1686629713;
		end
		for (int i = 0; i < 30; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv > 0) begin
				xv += dx; yv -= dy; ang += atan_step(i);
			end else begin
				xv -= dx; yv += dy; ang -= atan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic longint rad_to_deg(input longint r);
		longint unsigned m;
		bit neg;
		int sh;
		neg = r < 0;
		sh = 54 - F;
		if (r > 64'sd4294967296) r = 64'sd4294967296;
		if (r < -64'sd4294967296) r = -64'sd4294967296;
		m = neg ? longint'(-r) : longint'(r);
		m = (m * 64'd961263669 + (64'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Expected map position of one sky position
	function automatic map_pos_t aitoff_map(input logic signed [LON_W-1:0] lon_in,
			input logic signed [LAT_W-1:0] lat_in);
		longint lon, lat, sh, ch, sl, cl, c, s, alpha, nx, ny, xm, ym;
		longint unsigned c2;
		map_pos_t p;
		lon = lon_in;
		lat = lat_in;
		if (lon > (longint'(180) << F))
			lon -= longint'(360) << F;
		sin_cos(lon < 0 ? -lon : lon, sh, ch);
		sin_cos(2 * (lat < 0 ? -lat : lat), sl, cl);
		c = (cl * ch) >>> 30;
		c2 = c < 0 ? -c : c;
		c2 = c2 * c2;
		s = root64(c2 >= (64'd1 << 60) ? 64'd0 : (64'd1 << 60) - c2);
		alpha = vec_angle(s, c);
		if (alpha < 0)
			alpha = 0;
		nx = (cl * sh) >>> 29;
		ny = sl;
		if (s > 0) begin
			nx = nx * alpha / s;
			ny = ny * alpha / s;
		end
		xm = rad_to_deg(nx);
		ym = rad_to_deg(ny);
		if (lon >= 0) xm = -xm;
		if (lat < 0) ym = -ym;
		p.x = X_W'(clamp(xm, sat_lim(F, 180, X_W)));
		p.y = Y_W'(clamp(ym, sat_lim(F, 90, Y_W)));
		return p;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Send one position; start stays high across back-to-back transfers
	task automatic send_pos(input logic signed [LON_W-1:0] lon,
			input logic signed [LAT_W-1:0] lat);
		int gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		longitude <= lon;
		latitude <= lat;
		do @(posedge clk); while (busy);
		pending_pos.push_back(aitoff_map(lon, lat));
	endtask

	// Result checker
	always @(posedge clk) begin
		map_pos_t w;
		if (arst_n && done) begin
			if (pending_pos.size() == 0) begin
				report_mismatch("unexpected result", map_x, 0);
			end else begin
				w = pending_pos.pop_front();
				if (map_x !== w.x) report_mismatch("map_x", map_x, w.x);
				if (map_y !== w.y) report_mismatch("map_y", map_y, w.y);
			end
		end
	end

	task automatic test_directed();
		send_pos('0, '0);
		send_pos(LON_W'(180 << F), '0);
		send_pos(LON_W'((180 << F) + 1), '0);
		send_pos(LON_W'(360 << F), '0);
		send_pos(LON_W'(-(180 << F)), '0);
		send_pos('0, LAT_W'(90 << F));
		send_pos('0, LAT_W'(-(90 << F)));
		send_pos(LON_W'(180 << F), LAT_W'(90 << F));
		send_pos(LON_W'(-(180 << F)), LAT_W'(-(90 << F)));
		send_pos(LON_W'(-(360 << F)), '0);
		send_pos(LON_W'(1), LAT_W'(1));
		send_pos(LON_W'(-1), LAT_W'(-1));
		send_pos(LON_W'(90 << F), LAT_W'(45 << F));
		send_pos(LON_W'(270 << F), LAT_W'(-(45 << F)));
		send_pos({1'b0, {(LON_W-1){1'b1}}}, {1'b0, {(LAT_W-1){1'b1}}});
		send_pos({1'b1, {(LON_W-1){1'b0}}}, {1'b1, {(LAT_W-1){1'b0}}});
		send_pos('1, '1);
		send_pos(LON_W'((180 << F) - 1), LAT_W'((90 << F) - 1));
	endtask

	task automatic test_sky_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0)
				gaps_on = $urandom_range(0, 2) != 0;
			send_pos(LON_W'($urandom_range(0, 540 << F) - (180 << F)),
				LAT_W'($urandom_range(0, 180 << F) - (90 << F)));
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_raw_bits(input int n);
		for (int i = 0; i < n; i++)
			send_pos(LON_W'($urandom), LAT_W'($urandom));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_sky_random(1400);
		test_raw_bits(230);
		start <= 1'b0;
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
